### src/frwl_pkg.sv
package frwl_pkg;

  // request operation codes
  localparam logic [1:0] OP_ACQ_RD = 2'd0;
  localparam logic [1:0] OP_ACQ_WR = 2'd1;
  localparam logic [1:0] OP_REL_RD = 2'd2;
  localparam logic [1:0] OP_REL_WR = 2'd3;

  // result status codes
  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_REFUSED  = 3'd3;
  localparam logic [2:0] ST_BADREL   = 3'd4;
  localparam logic [2:0] ST_WOKEN    = 3'd5;

  localparam int AgentW = 4;

  // classified request, front to back
  typedef struct packed {
    logic              acquire;
    logic              write;
    logic              in_range;
    logic [AgentW-1:0] agent;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [2:0]        status;
    logic [AgentW-1:0] agent;
    logic              writer;
    logic              last;
  } res_t;

  // waiter entry: writer flag over agent number
  typedef struct packed {
    logic              writer;
    logic [AgentW-1:0] agent;
  } entry_t;

endpackage

### src/fair_reader_writer_lock_arbiter_unit.sv
// Fair FIFO reader-writer lock arbiter. Issue a request (acquire read,
// acquire write, release read, release write) with start_i while busy_o is
// low. Each request yields one result telling its own outcome, followed by
// one "woken grant" result per waiter that a release hands the lock to;
// last_o marks the final result of a request. Results appear for exactly one
// cycle with result_valid_o and cannot be held off, so the receiver must
// take every strobe. Requests go into a two-entry command queue; busy_o is
// high only while that queue is full. The lock engine takes a queued request
// when not waking waiters. A waking release reads each waiter entry from the
// registered read port of the waiter memory, then checks it; the last woken
// grant comes from a flush step, or from the check step when the run of
// readers stops at a waiting writer. There is no clearing pass after reset.
module fair_reader_writer_lock_arbiter_unit #(
  parameter int AGENTS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  operation_i,
  input  logic [frwl_pkg::AgentW-1:0] requester_i,
  output logic                        result_valid_o,
  output logic [2:0]                  status_o,
  output logic [frwl_pkg::AgentW-1:0] agent_o,
  output logic                        agent_is_writer_o,
  output logic                        last_o
);

  logic           push;
  logic           full;
  logic           pop;
  logic           cmd_valid;
  frwl_pkg::cmd_t cmd_in;
  frwl_pkg::cmd_t cmd_out;
  frwl_pkg::res_t res;

  // front: decode the operation, range-check the requester
  frwl_front #(.AGENTS(AGENTS)) u_front (
    .start_i     (start_i),
    .full_i      (full),
    .operation_i (operation_i),
    .requester_i (requester_i),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  // decouples request intake from the lock engine
  frwl_cmd_q u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out),
    .full_o  (full)
  );

  // back: lock state, waiter FIFO, wake-up sequencing
  frwl_back #(.AGENTS(AGENTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_o       (res)
  );

  assign busy_o            = full;
  assign status_o          = res.status;
  assign agent_o           = res.agent;
  assign agent_is_writer_o = res.writer;
  assign last_o            = res.last;

endmodule

### src/frwl_front.sv
module frwl_front #(
  parameter int AGENTS = 16
) (
  input  logic                          start_i,
  input  logic                          full_i,
  input  logic [1:0]                    operation_i,
  input  logic [frwl_pkg::AgentW-1:0]   requester_i,
  output logic                          push_o,
  output frwl_pkg::cmd_t                cmd_o
);

  localparam int CmpW = $clog2(AGENTS + 1) + frwl_pkg::AgentW;

  assign push_o = start_i && !full_i;

  always_comb begin
    cmd_o.acquire  = (operation_i == frwl_pkg::OP_ACQ_RD) ||
                     (operation_i == frwl_pkg::OP_ACQ_WR);
    cmd_o.write    = (operation_i == frwl_pkg::OP_ACQ_WR) ||
                     (operation_i == frwl_pkg::OP_REL_WR);
    cmd_o.in_range = CmpW'(requester_i) < CmpW'(AGENTS);
    cmd_o.agent    = requester_i;
  end

endmodule

### src/frwl_cmd_q.sv
module frwl_cmd_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  frwl_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           valid_o,
  output frwl_pkg::cmd_t cmd_o,
  output logic           full_o
);

  // two-entry ring
  frwl_pkg::cmd_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### src/frwl_back.sv
module frwl_back #(
  parameter int AGENTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  frwl_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           res_valid_o,
  output frwl_pkg::res_t res_o
);

  localparam int AW = $clog2(AGENTS);
  localparam int CW = $clog2(AGENTS + 1);
  localparam int SW = CW + 1;

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_RD    = 2'd1;
  localparam logic [1:0] S_CHK   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     readers_q, readers_d;
  logic              wr_hold_q, wr_hold_d;
  logic [AGENTS-1:0] holder_q, holder_d;
  logic [AGENTS-1:0] waiter_q, waiter_d;
  logic              pend_v_q, pend_v_d;
  frwl_pkg::entry_t  pend_q, pend_d;
  logic              res_v_q, res_v_d;
  frwl_pkg::res_t    res_q, res_d;

  frwl_pkg::entry_t  mem [AGENTS];
  frwl_pkg::entry_t  rdata_q;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  frwl_pkg::entry_t  wdata;
  logic              rd_en;

  logic [SW-1:0]     tail_sum;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     head_nxt;
  logic [AGENTS-1:0] cbit;
  logic [AGENTS-1:0] ebit;
  logic              rel_ok;
  logic              wake;
  logic [CW-1:0]     readers_rel;

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  always_comb begin
    tail_sum = SW'(head_q) + SW'(count_q);
    if (tail_sum >= SW'(AGENTS)) begin
      tail_sum = tail_sum - SW'(AGENTS);
    end
    tail     = AW'(tail_sum);
    head_nxt = (head_q == AW'(AGENTS - 1)) ? '0 : head_q + AW'(1);
    cbit     = cmd_i.in_range ? (AGENTS'(1) << cmd_i.agent) : '0;
    ebit     = AGENTS'(1) << rdata_q.agent;
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    readers_d = readers_q;
    wr_hold_d = wr_hold_q;
    holder_d  = holder_q;
    waiter_d  = waiter_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    res_v_d   = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    waddr     = tail;
    wdata     = '{writer: cmd_i.write, agent: cmd_i.agent};
    rd_en     = 1'b0;
    pop_o     = 1'b0;
    rel_ok    = 1'b0;
    wake      = 1'b0;
    readers_rel = readers_q - CW'(1);

    unique case (state_q)
      S_RUN: begin
        if (cmd_valid_i) begin
          pop_o      = 1'b1;
          res_v_d    = 1'b1;
          res_d.agent  = cmd_i.agent;
          res_d.writer = cmd_i.write;
          res_d.last   = 1'b1;
          if (cmd_i.acquire) begin
            if (!cmd_i.in_range || ((holder_q | waiter_q) & cbit) != '0) begin
              res_d.status = frwl_pkg::ST_REFUSED;
            end else if (count_q == '0 && !wr_hold_q &&
                         (!cmd_i.write || readers_q == '0)) begin
              holder_d = holder_q | cbit;
              if (cmd_i.write) begin
                wr_hold_d = 1'b1;
              end else begin
                readers_d = readers_q + CW'(1);
              end
              res_d.status = frwl_pkg::ST_GRANTED;
            end else begin
              mem_we   = 1'b1;
              count_d  = count_q + CW'(1);
              waiter_d = waiter_q | cbit;
              res_d.status = frwl_pkg::ST_QUEUED;
            end
          end else begin
            if ((holder_q & cbit) != '0) begin
              rel_ok = cmd_i.write ? wr_hold_q : (!wr_hold_q && readers_q != '0);
            end
            if (!rel_ok) begin
              res_d.status = frwl_pkg::ST_BADREL;
            end else begin
              holder_d = holder_q & ~cbit;
              if (cmd_i.write) begin
                wr_hold_d = 1'b0;
                wake      = (readers_q == '0) && (count_q != '0);
              end else begin
                readers_d = readers_rel;
                wake      = (readers_rel == '0) && (count_q != '0);
              end
              res_d.status = frwl_pkg::ST_RELEASED;
              res_d.last   = !wake;
              if (wake) begin
                pend_v_d = 1'b0;
                state_d  = S_RD;
              end
            end
          end
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        // a pending wake is always a reader; a writer at the head ends the run
        if (!pend_v_q || !rdata_q.writer) begin
          if (pend_v_q) begin
            res_v_d = 1'b1;
            res_d   = '{status: frwl_pkg::ST_WOKEN, agent: pend_q.agent,
                        writer: pend_q.writer, last: 1'b0};
          end
          head_d   = head_nxt;
          count_d  = count_q - CW'(1);
          waiter_d = waiter_q & ~ebit;
          holder_d = holder_q | ebit;
          if (rdata_q.writer) begin
            wr_hold_d = 1'b1;
          end else begin
            readers_d = readers_q + CW'(1);
          end
          pend_v_d = 1'b1;
          pend_d   = rdata_q;
          state_d  = (rdata_q.writer || count_q == CW'(1)) ? S_FLUSH : S_RD;
        end else begin
          res_v_d  = 1'b1;
          res_d    = '{status: frwl_pkg::ST_WOKEN, agent: pend_q.agent,
                       writer: pend_q.writer, last: 1'b1};
          pend_v_d = 1'b0;
          state_d  = S_RUN;
        end
      end
      S_FLUSH: begin
        res_v_d  = 1'b1;
        res_d    = '{status: frwl_pkg::ST_WOKEN, agent: pend_q.agent,
                     writer: pend_q.writer, last: 1'b1};
        pend_v_d = 1'b0;
        state_d  = S_RUN;
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RUN;
      head_q    <= '0;
      count_q   <= '0;
      readers_q <= '0;
      wr_hold_q <= 1'b0;
      holder_q  <= '0;
      waiter_q  <= '0;
      pend_v_q  <= 1'b0;
      res_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      readers_q <= readers_d;
      wr_hold_q <= wr_hold_d;
      holder_q  <= holder_d;
      waiter_q  <= waiter_d;
      pend_v_q  <= pend_v_d;
      res_v_q   <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[head_q];
    end
  end

endmodule

### verif/lock_grant_checker.sv
module lock_grant_checker
  import frwl_pkg::*;
#(
  parameter int AGENTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        operation_i,
  input  logic [AgentW-1:0] requester_i,
  input  logic              result_valid_i,
  input  logic [2:0]        status_i,
  input  logic [AgentW-1:0] agent_i,
  input  logic              writer_i,
  input  logic              last_i,
  output int                fail_count_o,
  output int                outstanding_o,
  output int                result_count_o,
  output int                wake_count_o,
  output int                longest_chain_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the lock
  entry_t            waiters_q[$];
  int unsigned       readers;
  logic              writer_in;
  logic [AGENTS-1:0] holders;
  logic [AGENTS-1:0] waiters;

  res_t expected_q[$];
  int   fails;
  int   results;
  int   wakes;
  int   longest;

  function automatic void expect_result(input logic [2:0] status,
                                        input logic [AgentW-1:0] agent,
                                        input logic writer);
    res_t r;
    r.status = status;
    r.agent  = agent;
    r.writer = writer;
    r.last   = 1'b0;
    expected_q.push_back(r);
  endfunction

  // hand the lock to the head waiter: one writer, or a run of readers
  function automatic void wake_waiters();
    entry_t head;
    while (waiters_q.size() > 0) begin
      head = waiters_q[0];
      if (head.writer ? (readers != 0 || writer_in) : writer_in) break;
      head = waiters_q.pop_front();
      waiters[head.agent] = 1'b0;
      holders[head.agent] = 1'b1;
      expect_result(ST_WOKEN, head.agent, head.writer);
      if (head.writer) begin
        writer_in = 1'b1;
        break;
      end
      readers++;
    end
  endfunction

  function automatic void predict_lock_request(input logic [1:0] op,
                                               input logic [AgentW-1:0] ag);
    logic wr;
    logic ok;
    int   first;
    wr    = (op == OP_ACQ_WR) || (op == OP_REL_WR);
    first = expected_q.size();
    if (op == OP_ACQ_RD || op == OP_ACQ_WR) begin
      if (ag >= AGENTS || holders[ag] || waiters[ag]) begin
        expect_result(ST_REFUSED, ag, wr);
      end else if (waiters_q.size() == 0 && !writer_in &&
                   (op == OP_ACQ_RD || readers == 0)) begin
        holders[ag] = 1'b1;
        if (op == OP_ACQ_RD) readers++;
        else writer_in = 1'b1;
        expect_result(ST_GRANTED, ag, wr);
      end else begin
        waiters_q.push_back('{writer: wr, agent: ag});
        waiters[ag] = 1'b1;
        expect_result(ST_QUEUED, ag, wr);
      end
    end else begin
      ok = 1'b0;
      if (ag < AGENTS && holders[ag]) begin
        if (op == OP_REL_WR && writer_in) ok = 1'b1;
        else if (op == OP_REL_RD && !writer_in && readers > 0) ok = 1'b1;
      end
      if (!ok) begin
        expect_result(ST_BADREL, ag, wr);
      end else begin
        holders[ag] = 1'b0;
        if (op == OP_REL_WR) writer_in = 1'b0;
        else readers--;
        expect_result(ST_RELEASED, ag, wr);
        if (!writer_in && readers == 0) wake_waiters();
      end
    end
    expected_q[expected_q.size()-1].last = 1'b1;
    if (expected_q.size() - first > longest) longest = expected_q.size() - first;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      waiters_q.delete();
      expected_q.delete();
      readers   = 0;
      writer_in = 1'b0;
      holders   = '0;
      waiters   = '0;
      fails     = 0;
      results   = 0;
      wakes     = 0;
      longest   = 0;
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (result_valid_i) begin
        results++;
        if (status_i == ST_WOKEN) wakes++;
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0d agent %0d writer %0d last %0d",
                 status_i, agent_i, writer_i, last_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fails++;
          end
          if (agent_i !== want.agent) begin
            $error("agent: expected %0d, got %0d", want.agent, agent_i);
            fails++;
          end
          if (writer_i !== want.writer) begin
            $error("agent_is_writer: expected %0d, got %0d", want.writer, writer_i);
            fails++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) predict_lock_request(operation_i, requester_i);
    end
    fail_count_o    <= fails;
    outstanding_o   <= expected_q.size();
    result_count_o  <= results;
    wake_count_o    <= wakes;
    longest_chain_o <= longest;
  end

endmodule

### verif/tb_fair_reader_writer_lock_arbiter_unit.sv
module tb_fair_reader_writer_lock_arbiter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import frwl_pkg::*;

  localparam int AGENTS          = 16;
  localparam int RANDOM_REQUESTS = 180;
  // allow plenty of room beyond what a full reader convoy needs
  localparam int IDLE_LIMIT      = 1000;
  localparam int DRAIN_CYCLES    = 50;

  // directed opening: {operation, requester}. Walks grants, queueing behind
  // readers, duplicate acquires (holder and waiter), wrong-kind and
  // non-holder releases, a writer woken by the last reader, a reader run
  // woken by a writer and stopped at the next waiting writer.
  localparam logic [5:0] DIRECTED [25] = '{
    {OP_ACQ_RD, 4'd0},  {OP_ACQ_RD, 4'd15}, {OP_ACQ_RD, 4'd0},  {OP_ACQ_WR, 4'd5},
    {OP_ACQ_RD, 4'd3},  {OP_ACQ_WR, 4'd5},  {OP_REL_WR, 4'd0},  {OP_REL_RD, 4'd7},
    {OP_REL_RD, 4'd0},  {OP_REL_RD, 4'd15}, {OP_REL_RD, 4'd5},  {OP_ACQ_RD, 4'd8},
    {OP_ACQ_RD, 4'd9},  {OP_ACQ_WR, 4'd10}, {OP_ACQ_RD, 4'd11}, {OP_REL_WR, 4'd5},
    {OP_REL_RD, 4'd3},  {OP_REL_RD, 4'd8},  {OP_REL_RD, 4'd9},  {OP_REL_WR, 4'd10},
    {OP_REL_RD, 4'd11}, {OP_ACQ_WR, 4'd12}, {OP_ACQ_RD, 4'd4},  {OP_REL_WR, 4'd12},
    {OP_REL_RD, 4'd4}
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic [1:0]        operation_i = OP_ACQ_RD;
  logic [AgentW-1:0] requester_i = '0;
  logic              busy_o;
  logic              result_valid_o;
  logic [2:0]        status_o;
  logic [AgentW-1:0] agent_o;
  logic              agent_is_writer_o;
  logic              last_o;

  int fail_count;
  int outstanding;
  int result_count;
  int wake_count;
  int longest_chain;
  int requests_sent = 0;
  int idle_cycles   = 0;

  // who holds or waits, as seen from results; only steers the stimulus
  logic [AGENTS-1:0] holds_rd;
  logic [AGENTS-1:0] holds_wr;
  logic [AGENTS-1:0] waiting;
  logic              no_gaps = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  fair_reader_writer_lock_arbiter_unit #(
    .AGENTS(AGENTS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .requester_i      (requester_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .agent_o          (agent_o),
    .agent_is_writer_o(agent_is_writer_o),
    .last_o           (last_o)
  );

  lock_grant_checker #(
    .AGENTS(AGENTS)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .operation_i    (operation_i),
    .requester_i    (requester_i),
    .result_valid_i (result_valid_o),
    .status_i       (status_o),
    .agent_i        (agent_o),
    .writer_i       (agent_is_writer_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .result_count_o (result_count),
    .wake_count_o   (wake_count),
    .longest_chain_o(longest_chain)
  );

  // track holders and waiters from the result stream
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holds_rd <= '0;
      holds_wr <= '0;
      waiting  <= '0;
    end else if (result_valid_o) begin
      case (status_o)
        ST_GRANTED, ST_WOKEN: begin
          if (agent_is_writer_o) holds_wr[agent_o] <= 1'b1;
          else holds_rd[agent_o] <= 1'b1;
          if (status_o == ST_WOKEN) waiting[agent_o] <= 1'b0;
        end
        ST_QUEUED: begin
          waiting[agent_o] <= 1'b1;
        end
        ST_RELEASED: begin
          if (agent_is_writer_o) holds_wr[agent_o] <= 1'b0;
          else holds_rd[agent_o] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // watchdog: nothing moving on either side for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive one request after a random gap and hold it until taken. With no
  // gap, start_i stays high from the previous request.
  task automatic issue(input logic [1:0] op, input logic [AgentW-1:0] ag);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    requester_i <= ag;
    do @(posedge clk_i); while (busy_o);
    requests_sent++;
  endtask

  // stop sending until every predicted result has come back
  task automatic wait_quiet();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // release holders until the lock is free with nobody waiting
  task automatic free_lock();
    int a;
    wait_quiet();
    while ((holds_rd | holds_wr | waiting) != '0) begin
      for (a = 0; a < AGENTS; a++) begin
        if (holds_wr[a]) issue(OP_REL_WR, a[AgentW-1:0]);
        else if (holds_rd[a]) issue(OP_REL_RD, a[AgentW-1:0]);
      end
      wait_quiet();
    end
  endtask

  // writer takes the free lock, a run of readers queues behind it, then the
  // writer lets go and the whole run is woken by that one release
  task automatic reader_convoy(input int count);
    logic [AgentW-1:0] w;
    int a;
    free_lock();
    w = AgentW'($urandom_range(0, AGENTS-1));
    issue(OP_ACQ_WR, w);
    for (a = 0; a < AGENTS && count > 0; a++) begin
      if (a[AgentW-1:0] != w) begin
        issue(OP_ACQ_RD, a[AgentW-1:0]);
        count--;
      end
    end
    issue(OP_REL_WR, w);
  endtask

  // Mostly well-formed traffic: acquires from agents not yet involved,
  // releases of the right kind by holders. A few requests are pure noise.
  task automatic random_request();
    int r;
    int tries;
    logic [AgentW-1:0] ag;
    r  = $urandom_range(0, 99);
    ag = AgentW'($urandom_range(0, AGENTS-1));
    if (r < 6) begin
      issue(2'($urandom_range(0, 3)), ag);
    end else if (r < 52 || (holds_rd | holds_wr) == '0) begin
      tries = 0;
      while ((holds_rd[ag] || holds_wr[ag] || waiting[ag]) && tries < 16) begin
        ag = AgentW'($urandom_range(0, AGENTS-1));
        tries++;
      end
      issue(($urandom_range(0, 9) < 3) ? OP_ACQ_WR : OP_ACQ_RD, ag);
    end else begin
      while (!(holds_rd[ag] || holds_wr[ag])) ag = AgentW'($urandom_range(0, AGENTS-1));
      issue(holds_wr[ag] ? OP_REL_WR : OP_REL_RD, ag);
    end
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) issue(DIRECTED[i][5:4], DIRECTED[i][3:0]);
    wait_quiet();

    // longest possible chain: one release, fifteen readers woken
    reader_convoy(AGENTS-1);

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      // some stretches back to back, the rest with random gaps
      if (n % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_REQUESTS / 2) reader_convoy($urandom_range(1, AGENTS-1));
      random_request();
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d lock requests; checked %0d results, %0d of them woken grants.",
             requests_sent, result_count, wake_count);
    $display("Longest result chain from a single request: %0d.", longest_chain);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
